// ===== sv/rbba_pkg.sv =====
// Shared item types, action codes and result codes of the RAM bank buffer allocator.
package rbba_pkg;

	// Actions carried by an input item.
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ALLOC = 2'd1;
	localparam logic [1:0] ACT_BANK  = 2'd2;
	localparam logic [1:0] ACT_DESC  = 2'd3;

	// Result codes.
	localparam logic [2:0] RC_OK      = 3'd0;
	localparam logic [2:0] RC_RANGE   = 3'd1;
	localparam logic [2:0] RC_STATUS  = 3'd2;
	localparam logic [2:0] RC_ID      = 3'd3;
	localparam logic [2:0] RC_BANK    = 3'd4;
	localparam logic [2:0] RC_NOBUF   = 3'd5;
	localparam logic [2:0] RC_BADBANK = 3'd6;

	// Owner id of a bank or buffer that nobody holds.
	localparam logic [7:0] FREE_ID = 8'hFF;

	// One input item.
	typedef struct packed {
		logic [1:0] action;
		logic [2:0] buffer_index;
		logic [7:0] new_id;
		logic [7:0] start_bank;
		logic [7:0] bank_cnt;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic [2:0] result_code;
		logic [7:0] owner_id;
		logic       is_allocated;
		logic [8:0] size_bytes;
		logic [2:0] first_bank;
	} rsp_t;

	// Controls from the sequencer to the bank owner store.
	typedef struct packed {
		logic clear;
		logic wr;
		logic rd;
	} bank_ctl_t;

endpackage

// ===== sv/ram_bank_buffer_allocator_top.sv =====
// Top level of the RAM bank buffer allocator: command sequencer, buffer descriptors, result register.

// Each item returns one result. A clear, a descriptor read or an allocation refused by its range
// or descriptor checks goes straight to the finish state; a bank read first reads and captures the
// owner of its bank. An allocation that passes its descriptor checks steps through its run bank by
// bank, because every bank of the run goes through the bank owner memory once to be checked
// (read, then compare) and once more to be written. When a bank of the run is found taken, the item
// ends at once with a bank collision code. The block takes one item at a time and holds stall high
// while it works; a finished result waits in its own output register, so the next item may be
// accepted before that result is taken. The owner memory is cleared at once by per-bank valid
// bits, so there is no clearing pass after reset.
module ram_bank_buffer_allocator_top #(
	parameter int NUM_BANKS   = 8,
	parameter int BANK_BYTES  = 32,
	parameter int NUM_BUFFERS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  rbba_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rbba_pkg::rsp_t rsp
);
	import rbba_pkg::*;

	localparam int BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int CW = $clog2(NUM_BANKS + 1);
	localparam int XW = $clog2(NUM_BUFFERS);
	localparam logic [8:0] BANK_BYTES_W = 9'(BANK_BYTES);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD   = 7'b0000010,
		ST_CMP  = 7'b0000100,
		ST_MARK = 7'b0001000,
		ST_BRD  = 7'b0010000,
		ST_BCAP = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	rsp_t res_q;
	rsp_t res_init;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic [BW-1:0] ptr_q;
	logic [CW-1:0] cnt_q;

	logic       buf_alloc_q [NUM_BUFFERS];
	logic [7:0] buf_id_q    [NUM_BUFFERS];
	logic [CW-1:0] buf_cnt_q [NUM_BUFFERS];
	logic [2:0] buf_base_q  [NUM_BUFFERS];

	logic accept;
	logic rsp_free;
	logic [XW-1:0] sel;
	logic [XW-1:0] sel_q;
	logic idx_ok;
	logic bank_ok;
	logic [8:0] span;
	logic [2:0] alloc_code;
	logic [8:0] size_prod;
	logic last;
	bank_ctl_t bank_ctl;
	logic [7:0] bank_rd;

	// Handshake.
	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Descriptor checks of an allocate item, in priority order.
	assign sel     = cmd.buffer_index[XW-1:0];
	assign sel_q   = cmd_q.buffer_index[XW-1:0];
	assign idx_ok  = {1'b0, cmd.buffer_index} < 4'(NUM_BUFFERS);
	assign bank_ok = cmd.start_bank < 8'(NUM_BANKS);
	assign span    = {1'b0, cmd.start_bank} + {1'b0, cmd.bank_cnt};

	always_comb begin
		if (span > 9'(NUM_BANKS) || cmd.bank_cnt == 8'd0) begin
			alloc_code = RC_RANGE;
		end else if (!idx_ok) begin
			alloc_code = RC_NOBUF;
		end else if (buf_alloc_q[sel]) begin
			alloc_code = RC_STATUS;
		end else if (buf_id_q[sel] != FREE_ID) begin
			alloc_code = RC_ID;
		end else begin
			alloc_code = RC_OK;
		end
	end

	// Buffer size of a descriptor read, kept to nine bits.
	assign size_prod = 9'(buf_cnt_q[sel]) * BANK_BYTES_W;
	assign last      = (cnt_q == CW'(1));

	// Result fields known at acceptance; fields an action does not name stay zero.
	always_comb begin
		res_init = '0;
		res_init.result_code = RC_OK;
		case (cmd.action)
			ACT_CLEAR: ;
			ACT_ALLOC: res_init.result_code = alloc_code;
			ACT_BANK: begin
				if (!bank_ok) begin
					res_init.result_code = RC_BADBANK;
					res_init.owner_id    = FREE_ID;
				end
			end
			default: begin
				if (idx_ok) begin
					res_init.owner_id     = buf_id_q[sel];
					res_init.is_allocated = buf_alloc_q[sel];
					res_init.size_bytes   = size_prod;
					res_init.first_bank   = buf_base_q[sel];
				end else begin
					res_init.result_code = RC_NOBUF;
					res_init.owner_id    = FREE_ID;
				end
			end
		endcase
	end

	// Bank owner memory, stepped one bank at a time by the sequencer.
	assign bank_ctl.clear = accept && (cmd.action == ACT_CLEAR);
	assign bank_ctl.wr    = (state_q == ST_MARK);
	assign bank_ctl.rd    = (state_q == ST_RD) || (state_q == ST_BRD);

	rbba_bank_store #(
		.NUM_BANKS(NUM_BANKS),
		.BW(BW)
	) u_bank_store (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(bank_ctl),
		.addr(ptr_q),
		.wdata(cmd_q.new_id),
		.rdata(bank_rd)
	);

	// Sequencer state, result valid and buffer descriptors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				buf_alloc_q[i] <= 1'b0;
				buf_id_q[i]    <= FREE_ID;
				buf_cnt_q[i]   <= '0;
				buf_base_q[i]  <= '0;
			end
		end else begin
			if (state_q == ST_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.action)
							ACT_CLEAR: begin
								for (int i = 0; i < NUM_BUFFERS; i++) begin
									buf_alloc_q[i] <= 1'b0;
									buf_id_q[i]    <= FREE_ID;
								end
								state_q <= ST_FIN;
							end
							ACT_ALLOC: state_q <= (alloc_code == RC_OK) ? ST_RD : ST_FIN;
							ACT_BANK:  state_q <= bank_ok ? ST_BRD : ST_FIN;
							default:   state_q <= ST_FIN;
						endcase
					end
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					if (bank_rd != FREE_ID) begin
						state_q <= ST_FIN;
					end else if (last) begin
						state_q <= ST_MARK;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_MARK: begin
					if (last) begin
						buf_alloc_q[sel_q] <= 1'b1;
						buf_id_q[sel_q]    <= cmd_q.new_id;
						buf_cnt_q[sel_q]   <= cmd_q.bank_cnt[CW-1:0];
						buf_base_q[sel_q]  <= cmd_q.start_bank[2:0];
						state_q <= ST_FIN;
					end
				end
				ST_BRD:  state_q <= ST_BCAP;
				ST_BCAP: state_q <= ST_FIN;
				ST_FIN: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item copy, bank pointer, remaining count and the result being built.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q <= cmd;
					ptr_q <= cmd.start_bank[BW-1:0];
					cnt_q <= cmd.bank_cnt[CW-1:0];
					res_q <= res_init;
				end
			end
			ST_CMP: begin
				if (bank_rd != FREE_ID) begin
					res_q.result_code <= RC_BANK;
				end else if (last) begin
					ptr_q <= cmd_q.start_bank[BW-1:0];
					cnt_q <= cmd_q.bank_cnt[CW-1:0];
				end else begin
					ptr_q <= ptr_q + 1'b1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_MARK: begin
				ptr_q <= ptr_q + 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_BCAP: res_q.owner_id <= bank_rd;
			ST_FIN: begin
				if (rsp_free) begin
					rsp_q <= res_q;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	// An accepted item keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd_stall)
		else $error("block not busy after accepting an item");

	// Banks are only written while some of the run remains.
	a_mark_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		bank_ctl.wr |-> (cnt_q != '0))
		else $error("bank write outside the allocated run");

	// A finished item reaches the output register as soon as it is free.
	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && rsp_free) |=> rsp_valid)
		else $error("finished item not offered");

	// A successful allocation never ends with a bank collision code pending.
	a_no_mark_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> (res_q.result_code == RC_OK))
		else $error("banks marked for a refused allocation");
`endif

endmodule

// ===== sv/rbba_bank_store.sv =====
// Bank owner memory with one write and one registered read port and per-bank valid bits.
module rbba_bank_store #(
	parameter int NUM_BANKS = 8,
	parameter int BW = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rbba_pkg::bank_ctl_t ctl,
	input  logic [BW-1:0]      addr,
	input  logic [7:0]         wdata,
	output logic [7:0]         rdata
);
	import rbba_pkg::*;

	logic [7:0] mem [NUM_BANKS];
	logic [NUM_BANKS-1:0] valid_q;
	logic [7:0] rd_data_q;
	logic rd_vld_q;

	// Owner bytes; a bank whose valid bit is clear reads as free.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
	end

	// Registered read of the data and of its valid bit.
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_data_q <= mem[addr];
			rd_vld_q  <= valid_q[addr];
		end
	end

	// Valid bits are cleared at reset and by a clear item, and set on a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.wr) begin
			valid_q[addr] <= 1'b1;
		end
	end

	assign rdata = rd_vld_q ? rd_data_q : FREE_ID;

endmodule
